@@ rtl/core/range_scan_to_pixel_stamps_assert.svh @@
// Assertion macros shared by the range scan stamper modules.
`ifndef RANGE_SCAN_TO_PIXEL_STAMPS_ASSERT_SVH
`define RANGE_SCAN_TO_PIXEL_STAMPS_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define RSPS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define RSPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RSPS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define RSPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/rsps_pkg.sv @@
package rsps_pkg;

   // Default geometry of the image and the stamp.
   localparam int DEF_IMAGE_SIZE   = 500;
   localparam int DEF_STAMP_RADIUS = 1;
   localparam int DEF_BEAM_COUNT   = 360;

   // Field widths of the channels.
   localparam int BEAM_W  = 9;
   localparam int RANGE_W = 16;
   localparam int PIX_W   = 9;

   // Stamp centers are carried at the width of the largest supported image.
   localparam int MAX_COORD_W = 12;
   // Pixel arithmetic in the back end, one bit above the coordinate width.
   localparam int PIX_CALC_W  = MAX_COORD_W + 1;

   // Stamp sequencing: loop indices cover 0..2*R with R at most 3.
   localparam int IDX_W       = 3;
   localparam int MAX_RESULTS = 9;
   localparam int CNT_W       = 4;

   // Queue between the front and the back end.
   localparam int QUEUE_DEPTH = 2;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MIN_RANGE = 1'b0;
   localparam logic REG_MAX_RANGE = 1'b1;
   localparam logic [RANGE_W-1:0] MIN_RANGE_RESET = 16'd256;
   localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 16'd60952;

   typedef struct packed {
      logic [RANGE_W-1:0] min_range;
      logic [RANGE_W-1:0] max_range;
   } limits_type;

   typedef struct packed {
      logic [MAX_COORD_W-1:0] x;
      logic [MAX_COORD_W-1:0] y;
   } stamp_center_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_STAMP = 2'b10
   } back_state_type;

   // Sine of 0..90 degrees in Q1.15, the last entry saturated.
   localparam logic signed [15:0] QUARTER_SINE [0:90] = '{
      16'sd0, 16'sd572, 16'sd1144, 16'sd1715, 16'sd2286, 16'sd2856, 16'sd3425,
      16'sd3993, 16'sd4560, 16'sd5126, 16'sd5690, 16'sd6252, 16'sd6813, 16'sd7371,
      16'sd7927, 16'sd8481, 16'sd9032, 16'sd9580, 16'sd10126, 16'sd10668,
      16'sd11207, 16'sd11743, 16'sd12275, 16'sd12803, 16'sd13328, 16'sd13848,
      16'sd14365, 16'sd14876, 16'sd15384, 16'sd15886, 16'sd16384, 16'sd16877,
      16'sd17364, 16'sd17847, 16'sd18324, 16'sd18795, 16'sd19261, 16'sd19720,
      16'sd20174, 16'sd20622, 16'sd21063, 16'sd21498, 16'sd21926, 16'sd22348,
      16'sd22763, 16'sd23170, 16'sd23571, 16'sd23965, 16'sd24351, 16'sd24730,
      16'sd25102, 16'sd25466, 16'sd25822, 16'sd26170, 16'sd26510, 16'sd26842,
      16'sd27166, 16'sd27482, 16'sd27789, 16'sd28088, 16'sd28378, 16'sd28660,
      16'sd28932, 16'sd29197, 16'sd29452, 16'sd29698, 16'sd29935, 16'sd30163,
      16'sd30382, 16'sd30592, 16'sd30792, 16'sd30983, 16'sd31164, 16'sd31336,
      16'sd31499, 16'sd31651, 16'sd31795, 16'sd31928, 16'sd32052, 16'sd32166,
      16'sd32270, 16'sd32365, 16'sd32449, 16'sd32524, 16'sd32588, 16'sd32643,
      16'sd32688, 16'sd32723, 16'sd32748, 16'sd32763, 16'sd32767
   };

   // Adds a quarter turn to an angle in degrees, wrapping at a full turn.
   function automatic logic [BEAM_W-1:0] add_quarter(input logic [BEAM_W-1:0] a);
      logic [BEAM_W:0] s;
      s = {1'b0, a} + 10'd90;
      if (s >= 10'd360) begin
         s = s - 10'd360;
      end
      return s[BEAM_W-1:0];
   endfunction

   // Sine in Q1.15 of an angle of 0..359 degrees, folded onto the quarter table.
   function automatic logic signed [15:0] sine_deg(input logic [BEAM_W-1:0] d);
      logic [BEAM_W-1:0] k;
      logic              neg;
      logic signed [15:0] s;
      neg = 1'b0;
      if (d <= 9'd90) begin
         k = d;
      end else if (d <= 9'd180) begin
         k = 9'd180 - d;
      end else if (d <= 9'd270) begin
         k = d - 9'd180;
         neg = 1'b1;
      end else begin
         k = 9'd360 - d;
         neg = 1'b1;
      end
      s = QUARTER_SINE[k[6:0]];
      return neg ? -s : s;
   endfunction

endpackage

@@ rtl/core/rsps_if.sv @@
// Sample channel into the stamper.
interface rsps_req_if;
   import rsps_pkg::*;
   logic               valid;
   logic               ready;
   logic [BEAM_W-1:0]  beam_index;
   logic [RANGE_W-1:0] range_q8;
   modport source (output valid, beam_index, range_q8, input ready);
   modport sink (input valid, beam_index, range_q8, output ready);
endinterface

// Pixel channel out of the stamper.
interface rsps_rsp_if;
   import rsps_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_col;
   logic [PIX_W-1:0] pixel_row;
   logic             last_pixel;
   modport source (output valid, pixel_col, pixel_row, last_pixel, input ready);
   modport sink (input valid, pixel_col, pixel_row, last_pixel, output ready);
endinterface

@@ rtl/core/rsps_csr.sv @@
module rsps_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rsps_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rsps_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rsps_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output rsps_pkg::limits_type               limits
);
   import rsps_pkg::*;

   limits_type limits_ff;
   limits_type limits_in;
   logic       wr_en;

   // Registers sit on word addresses; the byte offset bits are ignored.
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      limits_in = limits_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_MIN_RANGE: limits_in.min_range = pwdata[RANGE_W-1:0];
            REG_MAX_RANGE: limits_in.max_range = pwdata[RANGE_W-1:0];
            default:       limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.min_range <= MIN_RANGE_RESET;
         limits_ff.max_range <= MAX_RANGE_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   // Read data follows the address without wait states.
   always_comb begin
      unique case (paddr[2])
         REG_MIN_RANGE: prdata = CSR_DATA_W'(limits_ff.min_range);
         REG_MAX_RANGE: prdata = CSR_DATA_W'(limits_ff.max_range);
         default:       prdata = '0;
      endcase
   end

   assign limits = limits_ff;

endmodule

@@ rtl/core/rsps_front.sv @@
module rsps_front #(
   parameter int IMAGE_SIZE   = rsps_pkg::DEF_IMAGE_SIZE,
   parameter int STAMP_RADIUS = rsps_pkg::DEF_STAMP_RADIUS,
   parameter int BEAM_COUNT   = rsps_pkg::DEF_BEAM_COUNT
) (
   input  logic                           clock,
   input  logic                           reset,
   rsps_req_if.sink                       req,
   input  rsps_pkg::limits_type           limits,
   input  logic                           q_full,
   output logic                           push_valid,
   output rsps_pkg::stamp_center_type     push_data
);
   import rsps_pkg::*;

   localparam int AW = $clog2(IMAGE_SIZE);
   localparam int CW = (AW + 2 > 11) ? AW + 2 : 11;
   localparam logic [BEAM_W-1:0]  BEAM_LIM = BEAM_W'(BEAM_COUNT);
   localparam logic signed [CW-1:0] CENTER = CW'(IMAGE_SIZE / 2);
   localparam logic signed [CW-1:0] RAD    = CW'(STAMP_RADIUS);
   localparam logic signed [CW-1:0] LIM    = CW'(IMAGE_SIZE - 1);

   logic advance;
   logic sample_ok;
   logic [BEAM_W-1:0] theta;

   // Stage one: filtered sample with its cosine and sine.
   logic               s1_valid_ff, s1_valid_in;
   logic signed [15:0] s1_cos_ff, s1_cos_in;
   logic signed [15:0] s1_sin_ff, s1_sin_in;
   logic [RANGE_W-1:0] s1_range_ff, s1_range_in;

   // Stage two: products in Q23 pixels.
   logic               s2_valid_ff, s2_valid_in;
   logic signed [32:0] s2_px_ff, s2_px_in;
   logic signed [32:0] s2_py_ff, s2_py_in;

   logic signed [9:0]    off_x, off_y;
   logic signed [CW-1:0] cx, cy;
   logic                 in_image;

   // The pipeline moves unless a stamp that fits waits on a full queue.
   assign advance   = !(s2_valid_ff && in_image && q_full);
   assign req.ready = advance;

   // Range and beam filter, angle turned by a quarter so beam 0 points up.
   assign sample_ok = (req.beam_index < BEAM_LIM) &&
                      (req.range_q8 > limits.min_range) &&
                      (req.range_q8 < limits.max_range);
   assign theta     = add_quarter(req.beam_index);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_cos_in   = s1_cos_ff;
      s1_sin_in   = s1_sin_ff;
      s1_range_in = s1_range_ff;
      if (advance) begin
         s1_valid_in = req.valid && sample_ok;
         s1_cos_in   = sine_deg(add_quarter(theta));
         s1_sin_in   = sine_deg(theta);
         s1_range_in = req.range_q8;
      end
   end

   // One multiplier per axis, registered.
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_px_in    = s2_px_ff;
      s2_py_in    = s2_py_ff;
      if (advance) begin
         s2_valid_in = s1_valid_ff;
         s2_px_in    = s1_cos_ff * $signed({1'b0, s1_range_ff});
         s2_py_in    = s1_sin_ff * $signed({1'b0, s1_range_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cos_ff   <= s1_cos_in;
      s1_sin_ff   <= s1_sin_in;
      s1_range_ff <= s1_range_in;
      s2_px_ff    <= s2_px_in;
      s2_py_ff    <= s2_py_in;
   end

   // The upper product bits are the floor of the Q23 value.
   assign off_x = s2_px_ff[32:23];
   assign off_y = s2_py_ff[32:23];
   assign cx    = CENTER + CW'(off_x);
   assign cy    = CENTER + CW'(off_y);

   // The whole square must lie inside the image on both axes.
   assign in_image = (cx >= RAD) && (cx + RAD <= LIM) &&
                     (cy >= RAD) && (cy + RAD <= LIM);

   assign push_valid  = s2_valid_ff && in_image && !q_full;
   assign push_data.x = MAX_COORD_W'(cx[AW-1:0]);
   assign push_data.y = MAX_COORD_W'(cy[AW-1:0]);

endmodule

@@ rtl/core/rsps_queue.sv @@
`include "range_scan_to_pixel_stamps_assert.svh"
module rsps_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push_valid,
   input  rsps_pkg::stamp_center_type     push_data,
   output logic                           full,
   output logic                           pop_valid,
   output rsps_pkg::stamp_center_type     pop_data,
   input  logic                           pop
);
   import rsps_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   stamp_center_type entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == NW'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The front end must hold its stamp while the queue is full.
   `RSPS_ASSERT_IMPL(a_push_not_full, clock, reset, push_valid, !full, "push into full queue")
   `RSPS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= NW'(QUEUE_DEPTH), "count overrun")

endmodule

@@ rtl/core/rsps_back.sv @@
`include "range_scan_to_pixel_stamps_assert.svh"
module rsps_back #(
   parameter int IMAGE_SIZE   = rsps_pkg::DEF_IMAGE_SIZE,
   parameter int STAMP_RADIUS = rsps_pkg::DEF_STAMP_RADIUS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  rsps_pkg::stamp_center_type     q_data,
   output logic                           q_pop,
   rsps_rsp_if.source                     rsp
);
   import rsps_pkg::*;

   localparam logic [IDX_W-1:0]      SPAN    = IDX_W'(2 * STAMP_RADIUS);
   localparam logic [PIX_CALC_W-1:0] RAD_P   = PIX_CALC_W'(STAMP_RADIUS);
   localparam logic [PIX_CALC_W-1:0] LAST_RW = PIX_CALC_W'(IMAGE_SIZE - 1);
   localparam logic [CNT_W-1:0]      N_LAST  = CNT_W'(MAX_RESULTS - 1);

   back_state_type         state_ff, state_in;
   stamp_center_type       center_ff, center_in;
   logic [IDX_W-1:0]       i_ff, i_in;
   logic [IDX_W-1:0]       j_ff, j_in;
   logic [CNT_W-1:0]       n_ff, n_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]       col_ff, col_in;
   logic [PIX_W-1:0]       row_ff, row_in;
   logic                   last_ff, last_in;

   logic                   load;
   logic                   is_last;
   logic [PIX_CALC_W-1:0]  col_full, row_full;

   // The output register takes a new pixel when empty or being drained.
   assign load    = !rsp_valid_ff || rsp.ready;
   assign is_last = ((i_ff == SPAN) && (j_ff == SPAN)) || (n_ff == N_LAST);

   // Pixel of the current offset, rows counted from the top.
   assign col_full = PIX_CALC_W'(center_ff.x) - RAD_P + PIX_CALC_W'(i_ff);
   assign row_full = LAST_RW - (PIX_CALC_W'(center_ff.y) - RAD_P + PIX_CALC_W'(j_ff));

   // Stamp sequencer: one pixel per transfer slot, next center taken on the last.
   always_comb begin
      state_in     = state_ff;
      center_in    = center_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      col_in       = col_ff;
      row_in       = row_ff;
      last_in      = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               center_in = q_data;
               i_in      = '0;
               j_in      = '0;
               n_in      = '0;
               state_in  = ST_STAMP;
            end
         end
         ST_STAMP: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               col_in       = col_full[PIX_W-1:0];
               row_in       = row_full[PIX_W-1:0];
               last_in      = is_last;
               if (is_last) begin
                  i_in = '0;
                  j_in = '0;
                  n_in = '0;
                  if (q_valid) begin
                     q_pop     = 1'b1;
                     center_in = q_data;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  n_in = n_ff + 1'b1;
                  if (j_ff == SPAN) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      center_ff <= center_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      last_ff   <= last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pixel_col  = col_ff;
   assign rsp.pixel_row  = row_ff;
   assign rsp.last_pixel = last_ff;

   // Sequencer checks.
   `RSPS_ASSERT_IMPL(a_pop_has_data, clock, reset, q_pop, q_valid, "pop from empty queue")
   `RSPS_ASSERT_IMPL(a_count_cap, clock, reset,
      state_ff == ST_STAMP, n_ff <= N_LAST, "stamp count overrun")
   `RSPS_ASSERT_NEXT(a_last_idles, clock, reset,
      (state_ff == ST_STAMP) && load && is_last && !q_valid,
      (state_ff == ST_IDLE) && rsp_valid_ff && last_ff, "last pixel not closing stamp")

endmodule

@@ rtl/core/range_scan_to_pixel_stamps.sv @@
// Range scan to pixel stamps.
// The req channel carries one scanner sample per transfer: beam_index in whole
// degrees and range_q8 in 1/256 pixel units. Samples outside the beam count or
// not strictly between the min_range and max_range registers are dropped, as
// are samples whose stamp square would reach past the image border.
// Each kept sample produces up to nine transfers on the rsp channel, one pixel
// per cycle while rsp ready is high, dx outer and dy inner, with last_pixel set
// on the final one. A stamped sample yields (2*STAMP_RADIUS+1)^2 pixels, at
// most nine, which sets the sustained rate; a dropped sample costs only its
// input transfer. The front end (two pipeline stages: table lookup, multiply)
// feeds a two-entry queue, so samples keep entering while the back end is
// stamping. When the rsp receiver stalls, the current pixel is held and the
// queue fills; req ready falls once the queue is full and a stamp is waiting to
// enter it. Reset empties the pipeline and queue and loads min_range = 256 and
// max_range = 60952. The user must write the registers over the APB port only
// while idle; the block itself does not enforce this.
module range_scan_to_pixel_stamps #(
   parameter int IMAGE_SIZE   = rsps_pkg::DEF_IMAGE_SIZE,
   parameter int STAMP_RADIUS = rsps_pkg::DEF_STAMP_RADIUS,
   parameter int BEAM_COUNT   = rsps_pkg::DEF_BEAM_COUNT
) (
   input  logic                               clock,
   input  logic                               reset,
   rsps_req_if.sink                           req_chan,
   rsps_rsp_if.source                         rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rsps_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rsps_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rsps_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import rsps_pkg::*;

   limits_type       limits;
   logic             push_valid;
   stamp_center_type push_data;
   logic             q_full;
   logic             q_valid;
   stamp_center_type q_data;
   logic             q_pop;

   rsps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limits  (limits)
   );

   rsps_front #(
      .IMAGE_SIZE   (IMAGE_SIZE),
      .STAMP_RADIUS (STAMP_RADIUS),
      .BEAM_COUNT   (BEAM_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .limits     (limits),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   rsps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_data   (q_data),
      .pop        (q_pop)
   );

   rsps_back #(
      .IMAGE_SIZE   (IMAGE_SIZE),
      .STAMP_RADIUS (STAMP_RADIUS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule
